// File: rtl/drr_pkg.sv
package drr_pkg;

   // request opcodes
   localparam logic OP_DEPOSIT = 1'b0;
   localparam logic OP_READ    = 1'b1;

   // payload widths fixed by the channel definition
   localparam int OP_W        = 1;
   localparam int POS_W       = 8;
   localparam int BYTE_W      = 8;
   localparam int REMAIN_W    = 9;
   localparam int LEN_W       = 7;
   // wide enough for any ring size the block supports, plus one
   localparam int RING_CALC_W = 17;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FIRST = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_EMPTY = 4'b1000
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // take a read request, settle position and flags
      logic store;      // write a deposited byte into the ring
      logic issue;      // read the next ring slot and advance
      logic show_data;  // response carries a byte
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_read;    // request at the port is a read
      logic empty;      // read request will deliver no byte
      logic last_hit;   // byte on show is the final one of the burst
   } status_type;

endpackage

// File: rtl/drr_req_if.sv
interface drr_req_if;
   import drr_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [POS_W-1:0]    write_pos;
   logic [BYTE_W-1:0]   byte_in;
   logic                dma_wrapped;
   logic [REMAIN_W-1:0] dma_remaining;
   logic [LEN_W-1:0]    max_len;

   modport source (
      output valid, op, write_pos, byte_in, dma_wrapped, dma_remaining, max_len,
      input  ready
   );
   modport sink (
      input  valid, op, write_pos, byte_in, dma_wrapped, dma_remaining, max_len,
      output ready
   );

endinterface

// File: rtl/drr_rsp_if.sv
interface drr_rsp_if;
   import drr_pkg::*;

   logic              valid;
   logic              ready;
   logic              has_data;
   logic [BYTE_W-1:0] data_byte;
   logic              last;
   logic              data_lost;
   logic [LEN_W-1:0]  byte_count;

   modport source (
      output valid, has_data, data_byte, last, data_lost, byte_count,
      input  ready
   );
   modport sink (
      input  valid, has_data, data_byte, last, data_lost, byte_count,
      output ready
   );

endinterface

// File: rtl/dma_rx_ring_reader.sv
// deposit request: written to the ring when taken, ready again the next cycle, no response
// read request: taken in IDLE, ring read in FIRST, first byte shown in EMIT, then one byte
//    per cycle while rsp ready stays high, set by the single ring read port
// a read holds the block until its last response is taken; an empty read answers next cycle
// reset (synchronous): read position 0, wrap flag clear, no request in flight;
//    ring contents are not cleared
module dma_rx_ring_reader #(
   parameter int RING_SIZE = 256,
   parameter int MAX_BURST = 64
) (
   input  logic             clock,
   input  logic             reset,
   drr_req_if.sink          req_ch,
   drr_rsp_if.source        rsp_ch
);
   import drr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   drr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // ring store, positions and response payload
   drr_datapath #(
      .RING_SIZE (RING_SIZE),
      .MAX_BURST (MAX_BURST)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_ch.op),
      .req_write_pos     (req_ch.write_pos),
      .req_byte_in       (req_ch.byte_in),
      .req_dma_wrapped   (req_ch.dma_wrapped),
      .req_dma_remaining (req_ch.dma_remaining),
      .req_max_len       (req_ch.max_len),
      .rsp_has_data      (rsp_ch.has_data),
      .rsp_data_byte     (rsp_ch.data_byte),
      .rsp_last          (rsp_ch.last),
      .rsp_data_lost     (rsp_ch.data_lost),
      .rsp_byte_count    (rsp_ch.byte_count)
   );

endmodule

// File: rtl/drr_ctrl.sv
module drr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  drr_pkg::status_type status,
   output drr_pkg::cmd_type    cmd
);
   import drr_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.is_read == OP_READ) begin
                  cmd.load = 1'b1;
                  state_in = status.empty ? ST_EMPTY : ST_FIRST;
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         ST_FIRST: begin
            cmd.issue = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.show_data = 1'b1;
            if (rsp_ready) begin
               if (status.last_hit) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.issue = 1'b1;
               end
            end
         end
         ST_EMPTY: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // never take a request while a response is on show
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   // every ring read is followed by a byte on show
   a_issue_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> (state_ff == ST_EMIT))
      else $error("ring read not followed by byte response");

   // an empty response ends the request once taken
   a_empty_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMPTY) && rsp_ready |=> (state_ff == ST_IDLE))
      else $error("empty response did not end the request");

endmodule

// File: rtl/drr_datapath.sv
module drr_datapath #(
   parameter int RING_SIZE = 256,
   parameter int MAX_BURST = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  drr_pkg::cmd_type                     cmd,
   output drr_pkg::status_type                  status,
   input  logic [drr_pkg::OP_W-1:0]             req_op,
   input  logic [drr_pkg::POS_W-1:0]            req_write_pos,
   input  logic [drr_pkg::BYTE_W-1:0]           req_byte_in,
   input  logic                                 req_dma_wrapped,
   input  logic [drr_pkg::REMAIN_W-1:0]         req_dma_remaining,
   input  logic [drr_pkg::LEN_W-1:0]            req_max_len,
   output logic                                 rsp_has_data,
   output logic [drr_pkg::BYTE_W-1:0]           rsp_data_byte,
   output logic                                 rsp_last,
   output logic                                 rsp_data_lost,
   output logic [drr_pkg::LEN_W-1:0]            rsp_byte_count
);
   import drr_pkg::*;

   localparam int                     AW        = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
   localparam logic [RING_CALC_W-1:0] RING_EXT  = RING_CALC_W'(RING_SIZE);
   localparam logic [AW-1:0]          LAST_SLOT = AW'(RING_SIZE - 1);
   localparam logic [LEN_W-1:0]       BURST_CAP = LEN_W'(MAX_BURST);

   logic [BYTE_W-1:0] ring_mem [RING_SIZE];

   logic [AW-1:0]     rp_ff,    rp_in;
   logic              wp_ff,    wp_in;
   logic              lost_ff,  lost_in;
   logic [AW-1:0]     point_ff, point_in;
   logic [LEN_W-1:0]  want_ff,  want_in;
   logic [LEN_W-1:0]  cnt_ff,   cnt_in;
   logic [BYTE_W-1:0] rdata_ff;

   logic [RING_CALC_W-1:0] wpos_ext;
   logic [RING_CALC_W-1:0] rem_ext;
   logic [RING_CALC_W-1:0] rem_sat;
   logic [RING_CALC_W-1:0] point_ext;
   logic                   double_wrap;
   logic [AW-1:0]          rp_a;
   logic                   wp_a;
   logic                   behind;
   logic                   ahead;
   logic [AW-1:0]          rp_new;

   // deposit address range check
   assign wpos_ext = RING_CALC_W'(req_write_pos);

   // write point from the remaining count, saturated to the ring size
   always_comb begin
      rem_ext   = RING_CALC_W'(req_dma_remaining);
      rem_sat   = (rem_ext > RING_EXT) ? RING_EXT : rem_ext;
      point_ext = RING_EXT - rem_sat;
      point_in  = (point_ext == RING_EXT) ? '0 : point_ext[AW-1:0];
   end

   // overrun checks on a new read request
   always_comb begin
      double_wrap = req_dma_wrapped && wp_ff;
      rp_a        = double_wrap ? '0 : rp_ff;
      wp_a        = double_wrap ? 1'b0 : (req_dma_wrapped | wp_ff);
      behind      = !wp_a && (point_in < rp_a);
      ahead       = wp_a && (point_in >= rp_a);
      rp_new      = (behind || ahead) ? '0 : rp_a;
      want_in     = (req_max_len > BURST_CAP) ? BURST_CAP : req_max_len;
   end

   // position, flag and count updates
   always_comb begin
      rp_in   = rp_ff;
      wp_in   = wp_ff;
      lost_in = lost_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         rp_in   = rp_new;
         wp_in   = ahead ? 1'b0 : wp_a;
         lost_in = double_wrap || behind || ahead;
         cnt_in  = '0;
      end else if (cmd.issue) begin
         cnt_in = cnt_ff + LEN_W'(1);
         if (rp_ff == LAST_SLOT) begin
            rp_in = '0;
            wp_in = 1'b0;
         end else begin
            rp_in = rp_ff + AW'(1);
         end
      end
   end

   // read position and wrap flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff <= '0;
         wp_ff <= 1'b0;
      end else begin
         rp_ff <= rp_in;
         wp_ff <= wp_in;
      end
   end

   // per request burst registers
   always_ff @(posedge clock) begin
      lost_ff <= lost_in;
      cnt_ff  <= cnt_in;
      if (cmd.load) begin
         point_ff <= point_in;
         want_ff  <= want_in;
      end
   end

   // ring store
   always_ff @(posedge clock) begin
      if (cmd.store && (wpos_ext < RING_EXT)) begin
         ring_mem[wpos_ext[AW-1:0]] <= req_byte_in;
      end
      if (cmd.issue) begin
         rdata_ff <= ring_mem[rp_ff];
      end
   end

   // status to the controller
   always_comb begin
      status.is_read  = req_op[0];
      status.empty    = (want_in == '0) || (rp_new == point_in);
      status.last_hit = (cnt_ff == want_ff) || (rp_ff == point_ff);
   end

   // response payload
   assign rsp_has_data   = cmd.show_data;
   assign rsp_data_byte  = cmd.show_data ? rdata_ff : '0;
   assign rsp_last       = cmd.show_data ? status.last_hit : 1'b1;
   assign rsp_data_lost  = lost_ff;
   assign rsp_byte_count = cmd.show_data ? cnt_ff : '0;

   // each ring read counts one byte
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      cmd.issue && !$past(reset) |=> (cnt_ff == LEN_W'($past(cnt_ff) + LEN_W'(1))))
      else $error("byte count did not advance on ring read");

   // a shown byte stays within the burst
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cmd.show_data |-> (cnt_ff != '0) && (cnt_ff <= want_ff))
      else $error("byte count outside burst");

   // read position never leaves the ring
   a_rp_range: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= LAST_SLOT)
      else $error("read position outside ring");

endmodule

// File: verif/dma_rx_ring_reader_tb.sv
`timescale 1ns / 1ps

module dma_rx_ring_reader_tb;
   import drr_pkg::*;

   localparam int RING_SIZE    = 256;
   localparam int MAX_BURST    = 64;
   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 12;
   localparam int FILL_SLOTS   = RING_SIZE / 2;
   localparam int RAND_ITEMS   = 110;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_REPORTS  = 10;
   localparam int NO_LIMIT     = 128;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [POS_W-1:0]    write_pos;
      logic [BYTE_W-1:0]   byte_in;
      logic                dma_wrapped;
      logic [REMAIN_W-1:0] dma_remaining;
      logic [LEN_W-1:0]    max_len;
   } ring_req_t;

   typedef struct packed {
      logic              has_data;
      logic [BYTE_W-1:0] data_byte;
      logic              last;
      logic              data_lost;
      logic [LEN_W-1:0]  byte_count;
   } ring_beat_t;

   typedef struct {
      ring_req_t  req;
      bit         fixed;
      ring_beat_t fixed_beat;
   } dir_row_t;

   localparam ring_beat_t BEAT_EMPTY = '{has_data: 1'b0, data_byte: '0, last: 1'b1,
                                         data_lost: 1'b0, byte_count: '0};
   localparam ring_beat_t BEAT_EMPTY_LOST = '{has_data: 1'b0, data_byte: '0, last: 1'b1,
                                              data_lost: 1'b1, byte_count: '0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   drr_req_if req_ch();
   drr_rsp_if rsp_ch();

   dma_rx_ring_reader #(
      .RING_SIZE (RING_SIZE),
      .MAX_BURST (MAX_BURST)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // shadow copy of the reader state
   logic [BYTE_W-1:0] ring_shadow [RING_SIZE];
   bit                slot_written [RING_SIZE];
   int                shadow_rd;
   bit                shadow_wrap_pending;

   // responses still owed by the block, oldest first
   ring_beat_t due_beats [$];

   int send_idle_pct;
   int recv_stall_pct;
   int mismatches;
   int beats_checked;
   int reqs_sent;
   int reads_sent;
   int restarts_seen;
   int cycle_count;

   // expected responses of one request, state updated as it goes
   function automatic void drain_ring(input ring_req_t r, ref ring_beat_t beats [$]);
      int         point;
      int         want;
      int         rem;
      int         n;
      bit         lost;
      ring_beat_t b;
      beats.delete();
      n    = 0;
      lost = 1'b0;
      if (r.op == OP_DEPOSIT) begin
         ring_shadow[r.write_pos]  = r.byte_in;
         slot_written[r.write_pos] = 1'b1;
         return;
      end
      // double wrap check, else latch a new wrap
      if (r.dma_wrapped && shadow_wrap_pending) begin
         shadow_rd           = 0;
         shadow_wrap_pending = 1'b0;
         lost                = 1'b1;
      end else if (r.dma_wrapped) begin
         shadow_wrap_pending = 1'b1;
      end
      // dma write point from the remaining count
      rem   = (int'(r.dma_remaining) > RING_SIZE) ? RING_SIZE : int'(r.dma_remaining);
      point = (RING_SIZE - rem) % RING_SIZE;
      if (!shadow_wrap_pending && point == shadow_rd) begin
         beats.push_back(lost ? BEAT_EMPTY_LOST : BEAT_EMPTY);
         if (lost) restarts_seen++;
         return;
      end else if (!shadow_wrap_pending && point < shadow_rd) begin
         shadow_rd = 0;
         lost      = 1'b1;
      end else if (shadow_wrap_pending && point >= shadow_rd) begin
         shadow_rd           = 0;
         shadow_wrap_pending = 1'b0;
         lost                = 1'b1;
      end
      if (lost) restarts_seen++;
      want = (int'(r.max_len) > MAX_BURST) ? MAX_BURST : int'(r.max_len);
      // hand out bytes up to the write point, rolling over at the ring end
      while (n < want && shadow_rd != point) begin
         b.has_data  = 1'b1;
         b.data_byte = ring_shadow[shadow_rd];
         b.data_lost = lost;
         b.byte_count = LEN_W'(n + 1);
         shadow_rd++;
         if (shadow_rd >= RING_SIZE) begin
            shadow_rd           = 0;
            shadow_wrap_pending = 1'b0;
         end
         n++;
         b.last = (n == want) || (shadow_rd == point);
         beats.push_back(b);
      end
      if (n == 0) beats.push_back(lost ? BEAT_EMPTY_LOST : BEAT_EMPTY);
   endfunction

   // bytes a read may take before it meets a slot never deposited
   function automatic int readable_run(input ring_req_t r);
      int rd;
      bit pend;
      int rem;
      int point;
      int n;
      rd   = shadow_rd;
      pend = shadow_wrap_pending;
      n    = 0;
      if (r.dma_wrapped && pend) begin
         rd   = 0;
         pend = 1'b0;
      end else if (r.dma_wrapped) begin
         pend = 1'b1;
      end
      rem   = (int'(r.dma_remaining) > RING_SIZE) ? RING_SIZE : int'(r.dma_remaining);
      point = (RING_SIZE - rem) % RING_SIZE;
      if (!pend && point < rd) begin
         rd = 0;
      end else if (pend && point >= rd) begin
         rd = 0;
      end
      while (n < MAX_BURST && rd != point) begin
         if (!slot_written[rd]) return n;
         n++;
         rd++;
         if (rd >= RING_SIZE) rd = 0;
      end
      return NO_LIMIT;
   endfunction

   function automatic ring_req_t random_request();
      ring_req_t r;
      r.op            = OP_W'($urandom_range(0, 1));
      r.write_pos     = POS_W'($urandom_range(0, 255));
      r.byte_in       = BYTE_W'($urandom_range(0, 255));
      r.dma_wrapped   = 1'($urandom_range(0, 1));
      r.dma_remaining = REMAIN_W'($urandom_range(0, 511));
      r.max_len       = LEN_W'($urandom_range(0, 127));
      return r;
   endfunction

   function automatic dir_row_t row(input logic op, input int pos, input int val,
                                    input logic wr, input int rem, input int len,
                                    input bit fixed, input ring_beat_t fb);
      dir_row_t d;
      d.req.op            = op;
      d.req.write_pos     = POS_W'(pos);
      d.req.byte_in       = BYTE_W'(val);
      d.req.dma_wrapped   = wr;
      d.req.dma_remaining = REMAIN_W'(rem);
      d.req.max_len       = LEN_W'(len);
      d.fixed             = fixed;
      d.fixed_beat        = fb;
      return d;
   endfunction

   // drive one request from a falling edge, wait for the handshake
   task automatic send_request(input ring_req_t r, input bit fixed, input ring_beat_t fb);
      ring_beat_t beats [$];
      int         run;
      // keep reads to slots that have been deposited
      if (r.op == OP_READ) begin
         run = readable_run(r);
         if (int'(r.max_len) > run) r.max_len = LEN_W'(run);
      end
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.op            = r.op;
      req_ch.write_pos     = r.write_pos;
      req_ch.byte_in       = r.byte_in;
      req_ch.dma_wrapped   = r.dma_wrapped;
      req_ch.dma_remaining = r.dma_remaining;
      req_ch.max_len       = r.max_len;
      req_ch.valid         = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      drain_ring(r, beats);
      if (fixed && r.op == OP_READ) begin
         due_beats.push_back(fb);
      end else begin
         foreach (beats[i]) due_beats.push_back(beats[i]);
      end
      reqs_sent++;
      if (r.op == OP_READ) reads_sent++;
      @(negedge clock);
   endtask

   task automatic report_beat(input string why, input ring_beat_t e, input ring_beat_t g);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t: %s: expected has=%0d byte=%02h last=%0d lost=%0d count=%0d",
                  $realtime, why, e.has_data, e.data_byte, e.last, e.data_lost, e.byte_count);
         $display("%0t: %s: actual   has=%0d byte=%02h last=%0d lost=%0d count=%0d",
                  $realtime, why, g.has_data, g.data_byte, g.last, g.data_lost, g.byte_count);
      end
   endtask

   // response receiver stalls
   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // response checker
   always @(posedge clock) begin : rsp_check
      ring_beat_t got;
      ring_beat_t want_b;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.has_data   = rsp_ch.has_data;
         got.data_byte  = rsp_ch.data_byte;
         got.last       = rsp_ch.last;
         got.data_lost  = rsp_ch.data_lost;
         got.byte_count = rsp_ch.byte_count;
         beats_checked++;
         if (due_beats.size() == 0) begin
            report_beat("response with nothing due", BEAT_EMPTY, got);
         end else begin
            want_b = due_beats.pop_front();
            if (got.has_data !== want_b.has_data || got.data_byte !== want_b.data_byte ||
                got.last !== want_b.last || got.data_lost !== want_b.data_lost ||
                got.byte_count !== want_b.byte_count) begin
               report_beat("response mismatch", want_b, got);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still due",
                  cycle_count, due_beats.size());
         $display("** dma_rx_ring_reader: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      ring_req_t r;
      dir_row_t  dir_tbl [$];
      int        dma_ptr;
      bit        dma_lap;
      int        k;
      int        skip;
      int        pick;
      int        len_pick;
      int        rand_base;

      req_ch.valid         = 1'b0;
      req_ch.op            = OP_DEPOSIT;
      req_ch.write_pos     = '0;
      req_ch.byte_in       = '0;
      req_ch.dma_wrapped   = 1'b0;
      req_ch.dma_remaining = '0;
      req_ch.max_len       = '0;
      rsp_ch.ready         = 1'b0;
      send_idle_pct        = 31;
      recv_stall_pct       = 83;
      mismatches           = 0;
      beats_checked        = 0;
      reqs_sent            = 0;
      reads_sent           = 0;
      restarts_seen        = 0;
      cycle_count          = 0;
      shadow_rd            = 0;
      shadow_wrap_pending  = 1'b0;
      foreach (ring_shadow[i]) ring_shadow[i] = '0;
      foreach (slot_written[i]) slot_written[i] = 1'b0;

      // reset
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the lower half of the ring; reads stop short of unwritten slots
      for (int i = 0; i < FILL_SLOTS; i++) begin
         r           = random_request();
         r.op        = OP_DEPOSIT;
         r.write_pos = POS_W'(i);
         send_request(r, 1'b0, BEAT_EMPTY);
      end

      // directed table
      // reader state after reset, before any read
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 256, 64, 1'b1, BEAT_EMPTY));
      // remaining count saturates, burst cap on an empty read
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 511, 127, 1'b1, BEAT_EMPTY));
      // zero remaining means write point 0
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 0, 64, 1'b1, BEAT_EMPTY));
      // nothing wanted
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 200, 0, 1'b1, BEAT_EMPTY));
      // short of the cap, then capped, then a single byte
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 200, 127, 1'b0, BEAT_EMPTY));
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 56, 127, 1'b0, BEAT_EMPTY));
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 126, 1, 1'b0, BEAT_EMPTY));
      // dma behind the reader
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 200, 5, 1'b0, BEAT_EMPTY));
      // deposits at the slot extremes, then one more at slot 5
      dir_tbl.push_back(row(OP_DEPOSIT, 0, 8'h00, 1'b0, 0, 0, 1'b0, BEAT_EMPTY));
      dir_tbl.push_back(row(OP_DEPOSIT, 255, 8'hff, 1'b1, 511, 127, 1'b0, BEAT_EMPTY));
      dir_tbl.push_back(row(OP_DEPOSIT, 5, 8'ha5, 1'b0, 0, 0, 1'b0, BEAT_EMPTY));
      // wrap latched, then reading on towards the unfilled upper half
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b1, 256, 64, 1'b0, BEAT_EMPTY));
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 256, 127, 1'b0, BEAT_EMPTY));
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 250, 127, 1'b0, BEAT_EMPTY));
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 250, 127, 1'b0, BEAT_EMPTY));
      // second wrap while one is still pending
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b1, 250, 8, 1'b0, BEAT_EMPTY));
      // wrapped dma ahead: restart with nothing wanted, then with write point 0
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b1, 100, 0, 1'b1, BEAT_EMPTY_LOST));
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b1, 0, 64, 1'b1, BEAT_EMPTY_LOST));
      // double wrap
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 128, 64, 1'b0, BEAT_EMPTY));
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b1, 250, 2, 1'b0, BEAT_EMPTY));
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b1, 250, 4, 1'b0, BEAT_EMPTY));
      // drain to the write point, then caught up
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 250, 64, 1'b0, BEAT_EMPTY));
      dir_tbl.push_back(row(OP_READ, 0, 0, 1'b0, 250, 64, 1'b1, BEAT_EMPTY));
      foreach (dir_tbl[i]) send_request(dir_tbl[i].req, dir_tbl[i].fixed, dir_tbl[i].fixed_beat);

      // random part: mostly a dma filling the ring followed by a read, some noise
      dma_ptr   = shadow_rd;
      dma_lap   = 1'b0;
      rand_base = reqs_sent;
      while (reqs_sent - rand_base < RAND_ITEMS) begin
         if (reqs_sent - rand_base < RAND_ITEMS / 3) begin
            send_idle_pct  = 31;
            recv_stall_pct = 83;
         end else if (reqs_sent - rand_base < 2 * RAND_ITEMS / 3) begin
            send_idle_pct  = 83;
            recv_stall_pct = 31;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // dma deposits a few bytes at its own pointer
            k = $urandom_range(0, 6);
            repeat (k) begin
               r           = random_request();
               r.op        = OP_DEPOSIT;
               r.write_pos = POS_W'(dma_ptr);
               send_request(r, 1'b0, BEAT_EMPTY);
               dma_ptr++;
               if (dma_ptr >= RING_SIZE) begin
                  dma_ptr = 0;
                  dma_lap = 1'b1;
               end
            end
            // older traffic moves the pointer on, now and then past a whole lap
            skip    = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400)
                                                  : $urandom_range(0, 50);
            dma_ptr = dma_ptr + skip;
            if (dma_ptr >= RING_SIZE) begin
               dma_ptr = dma_ptr % RING_SIZE;
               dma_lap = 1'b1;
            end
            // software read matching the dma view
            len_pick        = $urandom_range(0, 99);
            r               = random_request();
            r.op            = OP_READ;
            r.dma_wrapped   = dma_lap;
            r.dma_remaining = REMAIN_W'(RING_SIZE - dma_ptr);
            r.max_len       = (len_pick < 5)  ? '0 :
                              (len_pick < 15) ? LEN_W'($urandom_range(65, 127)) :
                                                LEN_W'($urandom_range(1, 64));
            send_request(r, 1'b0, BEAT_EMPTY);
            dma_lap = 1'b0;
         end else if (pick < 88) begin
            // read with unrelated dma flags
            r    = random_request();
            r.op = OP_READ;
            send_request(r, 1'b0, BEAT_EMPTY);
         end else begin
            // stray deposit
            r    = random_request();
            r.op = OP_DEPOSIT;
            send_request(r, 1'b0, BEAT_EMPTY);
         end
      end

      // wait for every owed response, then let the block settle
      req_ch.valid = 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatches += due_beats.size();

      $display("%0d requests driven (%0d reads, %0d restarted on overrun)",
               reqs_sent, reads_sent, restarts_seen);
      $display("%0d responses checked, %0d mismatches, %0d cycles",
               beats_checked, mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("** dma_rx_ring_reader: PASSED **");
      end else begin
         $display("** dma_rx_ring_reader: FAILED **");
      end
      $finish;
   end

endmodule
